### rtl/salc_pkg.sv
// Package for the set-associative LRU cache tag store.
// Holds payload structs, action codes and the controller/datapath interface types.
package salc_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  localparam int AGE_W      = 3;
  localparam logic [AGE_W-1:0] AGE_MAX = 3'd7;

  localparam logic [1:0] ACT_LOAD   = 2'd0;
  localparam logic [1:0] ACT_STORE  = 2'd1;
  localparam logic [1:0] ACT_MODIFY = 2'd2;
  localparam logic [1:0] ACT_NOP    = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_SET_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_BITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WAYS     = 2'd2;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] address;
  } in_item_t;

  typedef struct packed {
    logic        was_hit;
    logic        was_miss;
    logic        was_eviction;
    logic        last_of_run;
    logic [31:0] hit_total;
    logic [31:0] miss_total;
    logic [31:0] eviction_total;
  } out_item_t;

  // Controller to datapath.
  typedef struct packed {
    logic load_item;  // capture the input beat
    logic rd_set;     // read the set of the captured address
    logic update;     // compare, update ways and counters, emit result
    logic last;       // this result ends the item
  } dp_cmd_t;

endpackage

### rtl/salc_ram.sv
// Generic single-port-write, registered-read RAM.
// No dependencies.
module salc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

### rtl/salc_ctrl.sv
// Controller state machine of the cache tag store.
// Depends on salc_pkg.
module salc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [1:0]        action,
  input  logic              init_busy,
  output logic              busy,
  output salc_pkg::dp_cmd_t cmd
);
  import salc_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       second_r, second_nxt;
  logic       accept;

  assign busy   = (state_r != S_IDLE) || init_busy;
  assign accept = start && !busy && (action != ACT_NOP);

  always_comb begin
    state_nxt     = state_r;
    second_nxt    = second_r;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        cmd.load_item = start;
        if (accept) begin
          state_nxt  = S_READ;
          second_nxt = (action == ACT_MODIFY);
        end
      end
      S_READ: begin
        cmd.rd_set = 1'b1;
        state_nxt  = S_UPD;
      end
      S_UPD: begin
        cmd.update = 1'b1;
        cmd.last   = !second_r;
        second_nxt = 1'b0;
        state_nxt  = second_r ? S_READ : S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      second_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      second_r <= second_nxt;
    end
  end
endmodule

### rtl/salc_dp.sv
// Datapath of the cache tag store: set RAMs, way compare, LRU update, counters.
// Depends on salc_pkg and salc_ram.
module salc_dp #(
  parameter int MAX_SET_BITS = 6,
  parameter int MAX_WAYS     = 8,
  parameter int ADDR_WIDTH   = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  salc_pkg::dp_cmd_t   cmd,
  input  logic [31:0]         address,
  input  logic [2:0]          set_bits,
  input  logic [4:0]          off_bits,
  input  logic [3:0]          ways_cfg,
  output logic                init_busy,
  output logic                out_valid,
  output salc_pkg::out_item_t out_data
);
  import salc_pkg::*;

  localparam int SETS  = 1 << MAX_SET_BITS;
  localparam int RDEP  = (SETS > 1) ? SETS : 2;
  localparam int RA_W  = $clog2(RDEP);
  localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int TAG_W = ADDR_WIDTH;
  localparam int SH_W  = 7;

  logic [31:0]        addr_r;
  logic [RA_W-1:0]    set_r;
  logic [TAG_W-1:0]   tag_r;
  logic               clearing_r;
  logic [RA_W-1:0]    clr_r;
  logic [31:0]        hit_cnt_r, miss_cnt_r, evict_cnt_r;
  logic               ov_r;
  out_item_t          od_r;

  // Address split (one barrel shift each; set and tag are registered along with the set read).
  logic [ADDR_WIDTH-1:0] a_m;
  logic [SH_W-1:0]       s_eff, tshift;
  logic [ADDR_WIDTH-1:0] a_off, set_mask;
  logic [4:0]            ways_eff;

  always_comb begin
    a_m    = ADDR_WIDTH'(addr_r);
    s_eff  = (32'(set_bits) > MAX_SET_BITS) ? SH_W'(MAX_SET_BITS) : SH_W'(set_bits);
    a_off  = (32'(off_bits) >= ADDR_WIDTH) ? '0 : (a_m >> off_bits);
    set_mask = ~({ADDR_WIDTH{1'b1}} << s_eff);
    tshift = SH_W'(off_bits) + s_eff;
    if (ways_cfg == 4'd0) ways_eff = 5'd1;
    else if (32'(ways_cfg) > MAX_WAYS) ways_eff = 5'(MAX_WAYS);
    else ways_eff = 5'(ways_cfg);
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) addr_r <= address;
    if (cmd.rd_set) begin
      set_r <= RA_W'(a_off & set_mask);
      tag_r <= (32'(tshift) >= ADDR_WIDTH) ? '0 : (a_m >> tshift);
    end
  end

  // Per-way RAMs, read at the set in READ, data valid in UPDATE. The top bit
  // of each tag entry is the line's valid bit.
  logic [TAG_W:0]   tag_q [MAX_WAYS];
  logic [AGE_W-1:0] age_q [MAX_WAYS];
  logic [AGE_W-1:0] age_n [MAX_WAYS];
  logic [MAX_WAYS-1:0] we_tag, vq;
  logic [RA_W-1:0]  rd_addr, wr_addr;
  logic [TAG_W:0]   tag_wd;

  assign rd_addr = RA_W'(a_off & set_mask);
  assign wr_addr = clearing_r ? clr_r : set_r;
  assign tag_wd  = clearing_r ? {(TAG_W+1){1'b0}} : {1'b1, tag_r};

  for (genvar w = 0; w < MAX_WAYS; w++) begin : g_way
    salc_ram #(.WIDTH(TAG_W + 1), .DEPTH(RDEP)) u_tag (
      .clk(clk), .we(clearing_r || we_tag[w]), .waddr(wr_addr), .wdata(tag_wd),
      .raddr(rd_addr), .rdata(tag_q[w]));
    salc_ram #(.WIDTH(AGE_W), .DEPTH(RDEP)) u_age (
      .clk(clk), .we(clearing_r || (cmd.update && (w < ways_eff))), .waddr(wr_addr),
      .wdata(clearing_r ? {AGE_W{1'b0}} : age_n[w]),
      .raddr(rd_addr), .rdata(age_q[w]));
    assign vq[w] = tag_q[w][TAG_W];
  end

  // Compare and LRU choice over at most MAX_WAYS entries.
  logic              hit, found;
  logic [WAY_W-1:0]  w_sel;
  logic [AGE_W-1:0]  best, limit;
  logic              evict;

  always_comb begin
    hit = 1'b0; found = 1'b0; w_sel = '0; best = '0;
    for (int i = MAX_WAYS - 1; i >= 0; i--) begin
      if (i < ways_eff && vq[i] && tag_q[i][TAG_W-1:0] == tag_r) begin
        hit = 1'b1; w_sel = WAY_W'(i);
      end
    end
    if (!hit) begin
      for (int i = MAX_WAYS - 1; i >= 0; i--) begin
        if (i < ways_eff && !vq[i]) begin
          found = 1'b1; w_sel = WAY_W'(i);
        end
      end
      if (!found) begin
        for (int i = 0; i < MAX_WAYS; i++) begin
          if (i < ways_eff && (i == 0 || age_q[i] > best)) begin
            best = age_q[i]; w_sel = WAY_W'(i);
          end
        end
      end
    end
    evict = !hit && !found;
    limit = age_q[w_sel];
    for (int i = 0; i < MAX_WAYS; i++) begin
      age_n[i] = age_q[i];
      if (WAY_W'(i) == w_sel) age_n[i] = '0;
      else if (vq[i] && (found || age_q[i] < limit) && age_q[i] < AGE_MAX)
        age_n[i] = age_q[i] + 1'b1;
    end
    for (int i = 0; i < MAX_WAYS; i++)
      we_tag[i] = cmd.update && !hit && (WAY_W'(i) == w_sel);
  end

  logic [31:0] hit_nxt, miss_nxt, evict_nxt;
  assign hit_nxt   = hit_cnt_r + 32'(hit);
  assign miss_nxt  = miss_cnt_r + 32'(!hit);
  assign evict_nxt = evict_cnt_r + 32'(evict);

  // After reset every set is walked once to mark all lines invalid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r  <= 1'b1;
      clr_r       <= '0;
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      evict_cnt_r <= '0;
      ov_r        <= 1'b0;
    end else begin
      if (clearing_r) begin
        clr_r <= clr_r + 1'b1;
        if (clr_r == RA_W'(RDEP - 1)) clearing_r <= 1'b0;
      end
      ov_r <= cmd.update;
      if (cmd.update) begin
        hit_cnt_r   <= hit_nxt;
        miss_cnt_r  <= miss_nxt;
        evict_cnt_r <= evict_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      od_r.was_hit        <= hit;
      od_r.was_miss       <= !hit;
      od_r.was_eviction   <= evict;
      od_r.last_of_run    <= cmd.last;
      od_r.hit_total      <= hit_nxt;
      od_r.miss_total     <= miss_nxt;
      od_r.eviction_total <= evict_nxt;
    end
  end

  assign init_busy = clearing_r;
  assign out_valid = ov_r;
  assign out_data  = od_r;
endmodule

### rtl/set_associative_lru_cache_tags_core.sv
// Top level of the set-associative LRU cache tag store.
// Depends on salc_pkg, salc_ctrl, salc_dp and salc_ram.
//
// An access is accepted when start is high, busy is low and the action is not
// 3. Load and store take one set access, modify takes two; each access is a
// read of the per-way tag and age RAMs in READ followed by an update in UPDATE,
// so busy stays high through READ and UPDATE for a load or store and through
// both twice for a modify. Each result is shown on out_item with out_valid high
// for one cycle, in the cycle after its update; the receiver cannot stall.
// Action 3 gives no result. After reset, busy stays high while a clearing pass
// marks every line of all 1 << MAX_SET_BITS sets (64 by default) invalid.
module set_associative_lru_cache_tags_core #(
  parameter int MAX_SET_BITS = 6,
  parameter int MAX_WAYS     = 8,
  parameter int ADDR_WIDTH   = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  salc_pkg::in_item_t                   in_item,
  output logic                                 out_valid,
  output salc_pkg::out_item_t                  out_item,
  input  logic                                 cfg_we,
  input  logic [salc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [salc_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import salc_pkg::*;

  logic [2:0] set_bits_r;
  logic [4:0] off_bits_r;
  logic [3:0] ways_r;
  dp_cmd_t    cmd;
  logic       init_busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_bits_r <= '0;
      off_bits_r <= '0;
      ways_r     <= 4'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SET_BITS: set_bits_r <= cfg_data[2:0];
        REG_OFF_BITS: off_bits_r <= cfg_data;
        REG_WAYS:     ways_r     <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  salc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .action(in_item.action),
    .init_busy(init_busy), .busy(busy), .cmd(cmd));

  salc_dp #(.MAX_SET_BITS(MAX_SET_BITS), .MAX_WAYS(MAX_WAYS), .ADDR_WIDTH(ADDR_WIDTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .address(in_item.address),
    .set_bits(set_bits_r), .off_bits(off_bits_r), .ways_cfg(ways_r),
    .init_busy(init_busy), .out_valid(out_valid), .out_data(out_item));
endmodule

### rtl/salc_checker.sv
// Port-level checker for the cache tag store, bound to the top level.
// Depends on salc_pkg.
module salc_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input salc_pkg::in_item_t  in_item,
  input logic                out_valid,
  input salc_pkg::out_item_t out_item
);
  import salc_pkg::*;

  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.was_hit != out_item.was_miss))
    else $error("hit and miss not exclusive");

  a_evict_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.was_eviction |-> out_item.was_miss)
    else $error("eviction without miss");

  a_second_hits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.last_of_run |=> ##1 (out_valid && out_item.was_hit))
    else $error("second access of modify missed");

  a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_item.action != ACT_NOP) |=> busy)
    else $error("accepted beat did not raise busy");

  a_no_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !busy && !$past(busy) |-> !out_valid)
    else $error("result without work");
endmodule

bind set_associative_lru_cache_tags_core salc_checker u_chk (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
  .out_valid(out_valid), .out_item(out_item));
